// ===== rtl/assert_macros.svh =====
// Assertion macros for the multi-pattern matcher RTL.
// Bodies fall away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MPM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("mpm check failed");
`define MPM_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("mpm check failed");
`else
`define MPM_ASSERT(label, clk, rst, prop)
`define MPM_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== rtl/mpm_pkg.sv =====
// Shared constants, codes and types of the multi-pattern matcher.
// No dependencies.
package mpm_pkg;
   localparam int MAX_NODES_DEF     = 256;
   localparam int MAX_PATTERNS_DEF  = 64;
   localparam int ALPHABET_SIZE_DEF = 26;
   localparam int POSITION_BITS_DEF = 32;
   localparam logic [7:0] LETTER_LOW  = 8'd65;
   localparam logic [7:0] LETTER_HIGH = 8'd90;
   localparam logic [6:0] RESULT_LIMIT = 7'd64;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_BUILD  = 3'd2;
   localparam logic [2:0] CMD_NEWTXT = 3'd3;
   localparam logic [2:0] CMD_TEXT   = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_UNBUILT = 2'd3;

   typedef struct packed {
      logic child;
      logic fail;
      logic outl;
      logic depth;
      logic first;
      logic lastp;
      logic pnext;
      logic bfs;
   } mpm_we_type;
endpackage

// ===== rtl/mpm_store.sv =====
// Automaton memories: trie, links, node data, pattern chain and BFS queue.
// Uses mpm_pkg; one write and one registered read per memory per cycle.
module mpm_store
   import mpm_pkg::*;
#(
   parameter int N  = MAX_NODES_DEF,
   parameter int P  = MAX_PATTERNS_DEF,
   parameter int A  = ALPHABET_SIZE_DEF,
   parameter int NW = $clog2(N),
   parameter int CW = $clog2(N * A),
   parameter int PW = $clog2(P + 1),
   parameter int PIW = (P > 1) ? $clog2(P) : 1
) (
   input  logic           clock,
   input  mpm_we_type     we,
   input  logic [CW-1:0]  child_wa,
   input  logic [NW-1:0]  child_wd,
   input  logic [CW-1:0]  child_ra,
   output logic [NW-1:0]  child_rd,
   input  logic [NW-1:0]  node_wa,
   input  logic [NW-1:0]  node_ra,
   input  logic [NW-1:0]  fail_wd,
   input  logic [NW-1:0]  outl_wd,
   input  logic [NW-1:0]  depth_wd,
   input  logic [PW-1:0]  first_wd,
   input  logic [PW-1:0]  lastp_wd,
   output logic [NW-1:0]  fail_rd,
   output logic [NW-1:0]  outl_rd,
   output logic [NW-1:0]  depth_rd,
   output logic [PW-1:0]  first_rd,
   output logic [PW-1:0]  lastp_rd,
   input  logic [PIW-1:0] pnext_wa,
   input  logic [PW-1:0]  pnext_wd,
   input  logic [PIW-1:0] pnext_ra,
   output logic [PW-1:0]  pnext_rd,
   input  logic [NW-1:0]  bfs_wa,
   input  logic [NW-1:0]  bfs_wd,
   input  logic [NW-1:0]  bfs_ra,
   output logic [NW-1:0]  bfs_rd
);
   logic [NW-1:0] child_mem [N*A];
   logic [NW-1:0] fail_mem  [N];
   logic [NW-1:0] outl_mem  [N];
   logic [NW-1:0] depth_mem [N];
   logic [PW-1:0] first_mem [N];
   logic [PW-1:0] lastp_mem [N];
   logic [PW-1:0] pnext_mem [P];
   logic [NW-1:0] bfs_mem   [N];

   always_ff @(posedge clock) begin
      if (we.child) child_mem[child_wa] <= child_wd;
      if (we.fail)  fail_mem[node_wa]   <= fail_wd;
      if (we.outl)  outl_mem[node_wa]   <= outl_wd;
      if (we.depth) depth_mem[node_wa]  <= depth_wd;
      if (we.first) first_mem[node_wa]  <= first_wd;
      if (we.lastp) lastp_mem[node_wa]  <= lastp_wd;
      if (we.pnext) pnext_mem[pnext_wa] <= pnext_wd;
      if (we.bfs)   bfs_mem[bfs_wa]     <= bfs_wd;
      child_rd <= child_mem[child_ra];
      fail_rd  <= fail_mem[node_ra];
      outl_rd  <= outl_mem[node_ra];
      depth_rd <= depth_mem[node_ra];
      first_rd <= first_mem[node_ra];
      lastp_rd <= lastp_mem[node_ra];
      pnext_rd <= pnext_mem[pnext_ra];
      bfs_rd   <= bfs_mem[bfs_ra];
   end
endmodule

// ===== rtl/mpm_ctrl.sv =====
// Command sequencer: clearing sweep, trie insertion, breadth-first link build
// and text walk with hit reporting. Uses mpm_pkg; drives mpm_store.
module mpm_ctrl
   import mpm_pkg::*;
#(
   parameter int N  = MAX_NODES_DEF,
   parameter int P  = MAX_PATTERNS_DEF,
   parameter int A  = ALPHABET_SIZE_DEF,
   parameter int PB = POSITION_BITS_DEF,
   parameter int NW = $clog2(N),
   parameter int CW = $clog2(N * A),
   parameter int PW = $clog2(P + 1),
   parameter int PIW = (P > 1) ? $clog2(P) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  logic [2:0]     req_command,
   input  logic [7:0]     req_letter,
   input  logic           req_last_letter,
   output logic           rsp_valid,
   output logic [1:0]     rsp_status,
   output logic           rsp_found,
   output logic [5:0]     rsp_pattern_index,
   output logic [31:0]    rsp_start_position,
   output logic           rsp_last,
   output mpm_we_type     we,
   output logic [CW-1:0]  child_wa,
   output logic [NW-1:0]  child_wd,
   output logic [CW-1:0]  child_ra,
   input  logic [NW-1:0]  child_rd,
   output logic [NW-1:0]  node_wa,
   output logic [NW-1:0]  node_ra,
   output logic [NW-1:0]  fail_wd,
   output logic [NW-1:0]  outl_wd,
   output logic [NW-1:0]  depth_wd,
   output logic [PW-1:0]  first_wd,
   output logic [PW-1:0]  lastp_wd,
   input  logic [NW-1:0]  fail_rd,
   input  logic [NW-1:0]  outl_rd,
   input  logic [NW-1:0]  depth_rd,
   input  logic [PW-1:0]  first_rd,
   input  logic [PW-1:0]  lastp_rd,
   output logic [PIW-1:0] pnext_wa,
   output logic [PW-1:0]  pnext_wd,
   output logic [PIW-1:0] pnext_ra,
   input  logic [PW-1:0]  pnext_rd,
   output logic [NW-1:0]  bfs_wa,
   output logic [NW-1:0]  bfs_wd,
   output logic [NW-1:0]  bfs_ra,
   input  logic [NW-1:0]  bfs_rd
);
   localparam int AW  = $clog2(A);
   localparam int SWL = (N * A > P) ? N * A : P;
   localparam int SW  = $clog2(SWL);

   typedef enum logic [20:0] {
      S_SWEEP  = 21'h000001, S_IDLE   = 21'h000002, S_INS1   = 21'h000004,
      S_INS2   = 21'h000008, S_BR_RD  = 21'h000010, S_BR_CK  = 21'h000020,
      S_B_POP  = 21'h000040, S_B_U    = 21'h000080, S_B_FU   = 21'h000100,
      S_B_CRD  = 21'h000200, S_B_CCK  = 21'h000400, S_B_FRD  = 21'h000800,
      S_B_FCK  = 21'h001000, S_B_FNX  = 21'h002000, S_B_OUT  = 21'h004000,
      S_T_CRD  = 21'h008000, S_T_CCK  = 21'h010000, S_T_FNX  = 21'h020000,
      S_T_LIST = 21'h040000, S_T_EMIT = 21'h080000, S_T_PN   = 21'h100000
   } state_type;

   state_type     state_ff, state_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic          swrsp_ff, swrsp_in;
   logic [AW-1:0] c_ff, c_in;
   logic          fin_ff, fin_in;
   logic [NW:0]   ncount_ff, ncount_in;
   logic [PW-1:0] pcount_ff, pcount_in;
   logic [NW-1:0] ins_node_ff, ins_node_in;
   logic [NW-1:0] ins_dep_ff, ins_dep_in;
   logic [NW-1:0] txt_node_ff, txt_node_in;
   logic [PB-1:0] pos_ff, pos_in;
   logic          built_ff, built_in;
   logic [NW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [AW:0]   cc_ff, cc_in;
   logic [NW-1:0] u_ff, u_in, fu_ff, fu_in, v_ff, v_in, t_ff, t_in;
   logic [NW-1:0] walk_ff, walk_in, o_ff, o_in, dep_ff, dep_in;
   logic [PW-1:0] p_ff, p_in, pat_ff, pat_in;
   logic [6:0]    nh_ff, nh_in;
   logic          pend_ff, pend_in;
   logic [5:0]    pend_idx_ff, pend_idx_in;
   logic [31:0]   pend_st_ff, pend_st_in;
   logic          rv_ff, rv_in, rf_ff, rf_in, rl_ff, rl_in;
   logic [1:0]    rs_ff, rs_in;
   logic [5:0]    ri_ff, ri_in;
   logic [31:0]   rp_ff, rp_in;
   logic [7:0]    lidx;
   logic          good;
   logic [NW-1:0] newv;
   logic [PB-1:0] hit_st;

   assign lidx = req_letter - LETTER_LOW;
   assign good = (req_letter >= LETTER_LOW) && (req_letter <= LETTER_HIGH) &&
                 (int'(lidx) < A);
   assign hit_st = pos_ff + PB'(1) - PB'(dep_ff);
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_found = rf_ff;
   assign rsp_pattern_index = ri_ff;
   assign rsp_start_position = rp_ff;
   assign rsp_last = rl_ff;

   always_comb begin
      state_in = state_ff;  sweep_in = sweep_ff;  swrsp_in = swrsp_ff;
      c_in = c_ff;  fin_in = fin_ff;  ncount_in = ncount_ff;  pcount_in = pcount_ff;
      ins_node_in = ins_node_ff;  ins_dep_in = ins_dep_ff;  txt_node_in = txt_node_ff;
      pos_in = pos_ff;  built_in = built_ff;  head_in = head_ff;  tail_in = tail_ff;
      cc_in = cc_ff;  u_in = u_ff;  fu_in = fu_ff;  v_in = v_ff;  t_in = t_ff;
      walk_in = walk_ff;  o_in = o_ff;  dep_in = dep_ff;  p_in = p_ff;  pat_in = pat_ff;
      nh_in = nh_ff;  pend_in = pend_ff;  pend_idx_in = pend_idx_ff;
      pend_st_in = pend_st_ff;
      rv_in = 1'b0;  rs_in = rs_ff;  rf_in = rf_ff;  ri_in = ri_ff;  rp_in = rp_ff;
      rl_in = rl_ff;
      we = '0;  child_wa = '0;  child_wd = '0;  child_ra = '0;
      node_wa = '0;  node_ra = '0;  fail_wd = '0;  outl_wd = '0;  depth_wd = '0;
      first_wd = PW'(P);  lastp_wd = PW'(P);
      pnext_wa = '0;  pnext_wd = PW'(P);  pnext_ra = '0;
      bfs_wa = '0;  bfs_wd = '0;  bfs_ra = '0;
      newv = '0;
      case (state_ff)
         S_SWEEP: begin
            child_wa = CW'(sweep_ff);
            we.child = (int'(sweep_ff) < N * A);
            node_wa = NW'(sweep_ff);
            we.fail  = (int'(sweep_ff) < N);
            we.outl  = (int'(sweep_ff) < N);
            we.depth = (int'(sweep_ff) < N);
            we.first = (int'(sweep_ff) < N);
            we.lastp = (int'(sweep_ff) < N);
            pnext_wa = PIW'(sweep_ff);
            we.pnext = (int'(sweep_ff) < P);
            sweep_in = sweep_ff + SW'(1);
            if (int'(sweep_ff) == SWL - 1) begin
               state_in = S_IDLE;
               if (swrsp_ff) begin
                  rv_in = 1'b1;  rs_in = ST_OK;  rf_in = 1'b0;  ri_in = '0;
                  rp_in = '0;  rl_in = 1'b1;
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               c_in = AW'(lidx);
               fin_in = req_last_letter;
               rs_in = ST_OK;  rf_in = 1'b0;  ri_in = '0;  rp_in = '0;  rl_in = 1'b1;
               case (req_command)
                  CMD_CLEAR: begin
                     state_in = S_SWEEP;  sweep_in = '0;  swrsp_in = 1'b1;
                     ncount_in = (NW+1)'(1);  pcount_in = '0;  ins_node_in = '0;
                     ins_dep_in = '0;  txt_node_in = '0;  pos_in = '0;
                     built_in = 1'b0;
                  end
                  CMD_INSERT: begin
                     if (!good) begin
                        ins_node_in = '0;  ins_dep_in = '0;
                        rv_in = 1'b1;  rs_in = ST_RANGE;
                     end else if (req_last_letter && int'(pcount_ff) >= P) begin
                        ins_node_in = '0;  ins_dep_in = '0;
                        rv_in = 1'b1;  rs_in = ST_FULL;
                     end else begin
                        child_ra = CW'(CW'(ins_node_ff) * CW'(A) + CW'(lidx));
                        state_in = S_INS1;
                     end
                  end
                  CMD_BUILD: begin
                     head_in = '0;  tail_in = '0;  cc_in = '0;  state_in = S_BR_RD;
                  end
                  CMD_NEWTXT: begin
                     txt_node_in = '0;  pos_in = '0;  rv_in = 1'b1;
                  end
                  CMD_TEXT: begin
                     if (!good) begin
                        rv_in = 1'b1;  rs_in = ST_RANGE;
                     end else if (!built_ff) begin
                        rv_in = 1'b1;  rs_in = ST_UNBUILT;
                     end else begin
                        walk_in = txt_node_ff;  state_in = S_T_CRD;
                     end
                  end
                  default: begin
                     rv_in = 1'b1;
                  end
               endcase
            end
         end
         S_INS1: begin
            if (child_rd == '0 && int'(ncount_ff) >= N) begin
               ins_node_in = '0;  ins_dep_in = '0;
               rv_in = 1'b1;  rs_in = ST_FULL;  state_in = S_IDLE;
            end else begin
               newv = child_rd;
               if (child_rd == '0) begin
                  newv = NW'(ncount_ff);
                  ncount_in = ncount_ff + (NW+1)'(1);
                  child_wa = CW'(CW'(ins_node_ff) * CW'(A) + CW'(c_ff));
                  child_wd = newv;  we.child = 1'b1;
                  node_wa = newv;  depth_wd = ins_dep_ff + NW'(1);  we.depth = 1'b1;
               end
               built_in = 1'b0;
               if (fin_ff) begin
                  v_in = newv;  node_ra = newv;  pat_in = pcount_ff;
                  pcount_in = pcount_ff + PW'(1);  state_in = S_INS2;
               end else begin
                  ins_node_in = newv;  ins_dep_in = ins_dep_ff + NW'(1);
                  rv_in = 1'b1;  state_in = S_IDLE;
               end
            end
         end
         S_INS2: begin
            node_wa = v_ff;
            if (int'(first_rd) >= P) begin
               first_wd = pat_ff;  we.first = 1'b1;
            end else begin
               pnext_wa = PIW'(lastp_rd);  pnext_wd = pat_ff;  we.pnext = 1'b1;
            end
            lastp_wd = pat_ff;  we.lastp = 1'b1;
            ins_node_in = '0;  ins_dep_in = '0;
            rv_in = 1'b1;  state_in = S_IDLE;
         end
         S_BR_RD: begin
            if (int'(cc_ff) == A) begin
               state_in = S_B_POP;
            end else begin
               child_ra = CW'(cc_ff);  state_in = S_BR_CK;
            end
         end
         S_BR_CK: begin
            if (child_rd != '0) begin
               bfs_wa = tail_ff;  bfs_wd = child_rd;  we.bfs = 1'b1;
               tail_in = tail_ff + NW'(1);
               node_wa = child_rd;  we.fail = 1'b1;  we.outl = 1'b1;
            end
            cc_in = cc_ff + (AW+1)'(1);  state_in = S_BR_RD;
         end
         S_B_POP: begin
            if (head_ff == tail_ff) begin
               built_in = 1'b1;  rv_in = 1'b1;  state_in = S_IDLE;
            end else begin
               bfs_ra = head_ff;  state_in = S_B_U;
            end
         end
         S_B_U: begin
            u_in = bfs_rd;  head_in = head_ff + NW'(1);  node_ra = bfs_rd;
            state_in = S_B_FU;
         end
         S_B_FU: begin
            fu_in = fail_rd;  cc_in = '0;  state_in = S_B_CRD;
         end
         S_B_CRD: begin
            if (int'(cc_ff) == A) begin
               state_in = S_B_POP;
            end else begin
               child_ra = CW'(CW'(u_ff) * CW'(A) + CW'(cc_ff));  state_in = S_B_CCK;
            end
         end
         S_B_CCK: begin
            if (child_rd == '0) begin
               cc_in = cc_ff + (AW+1)'(1);  state_in = S_B_CRD;
            end else begin
               v_in = child_rd;  walk_in = fu_ff;  state_in = S_B_FRD;
            end
         end
         S_B_FRD: begin
            child_ra = CW'(CW'(walk_ff) * CW'(A) + CW'(cc_ff));  state_in = S_B_FCK;
         end
         S_B_FCK: begin
            if (walk_ff != '0 && child_rd == '0) begin
               node_ra = walk_ff;  state_in = S_B_FNX;
            end else begin
               newv = (child_rd == v_ff) ? '0 : child_rd;
               t_in = newv;  node_wa = v_ff;  fail_wd = newv;  we.fail = 1'b1;
               node_ra = newv;  state_in = S_B_OUT;
            end
         end
         S_B_FNX: begin
            walk_in = fail_rd;  state_in = S_B_FRD;
         end
         S_B_OUT: begin
            node_wa = v_ff;
            outl_wd = (int'(first_rd) < P) ? t_ff : outl_rd;
            we.outl = 1'b1;
            bfs_wa = tail_ff;  bfs_wd = v_ff;  we.bfs = 1'b1;
            tail_in = tail_ff + NW'(1);
            cc_in = cc_ff + (AW+1)'(1);  state_in = S_B_CRD;
         end
         S_T_CRD: begin
            child_ra = CW'(CW'(walk_ff) * CW'(A) + CW'(c_ff));  state_in = S_T_CCK;
         end
         S_T_CCK: begin
            if (walk_ff != '0 && child_rd == '0) begin
               node_ra = walk_ff;  state_in = S_T_FNX;
            end else begin
               txt_node_in = child_rd;  node_ra = child_rd;  nh_in = '0;
               state_in = S_T_LIST;
            end
         end
         S_T_FNX: begin
            walk_in = fail_rd;  state_in = S_T_CRD;
         end
         S_T_LIST: begin
            p_in = first_rd;  dep_in = depth_rd;  o_in = outl_rd;  state_in = S_T_EMIT;
         end
         S_T_EMIT: begin
            if (int'(p_ff) < P && nh_ff < RESULT_LIMIT) begin
               if (pend_ff) begin
                  rv_in = 1'b1;  rs_in = ST_OK;  rf_in = 1'b1;  ri_in = pend_idx_ff;
                  rp_in = pend_st_ff;  rl_in = 1'b0;
               end
               pend_in = 1'b1;  pend_idx_in = 6'(p_ff);  pend_st_in = 32'(hit_st);
               nh_in = nh_ff + 7'd1;  pnext_ra = PIW'(p_ff);  state_in = S_T_PN;
            end else if (o_ff != '0 && nh_ff < RESULT_LIMIT) begin
               node_ra = o_ff;  state_in = S_T_LIST;
            end else begin
               pos_in = pos_ff + PB'(1);
               rv_in = 1'b1;  rs_in = ST_OK;  rl_in = 1'b1;
               rf_in = pend_ff;
               ri_in = pend_ff ? pend_idx_ff : 6'd0;
               rp_in = pend_ff ? pend_st_ff : 32'd0;
               pend_in = 1'b0;  state_in = S_IDLE;
            end
         end
         S_T_PN: begin
            p_in = pnext_rd;  state_in = S_T_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;  sweep_ff <= '0;  swrsp_ff <= 1'b0;
         ncount_ff <= (NW+1)'(1);  pcount_ff <= '0;  ins_node_ff <= '0;
         ins_dep_ff <= '0;  txt_node_ff <= '0;  pos_ff <= '0;  built_ff <= 1'b0;
         head_ff <= '0;  tail_ff <= '0;  cc_ff <= '0;  nh_ff <= '0;
         pend_ff <= 1'b0;  rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  sweep_ff <= sweep_in;  swrsp_ff <= swrsp_in;
         ncount_ff <= ncount_in;  pcount_ff <= pcount_in;  ins_node_ff <= ins_node_in;
         ins_dep_ff <= ins_dep_in;  txt_node_ff <= txt_node_in;  pos_ff <= pos_in;
         built_ff <= built_in;  head_ff <= head_in;  tail_ff <= tail_in;
         cc_ff <= cc_in;  nh_ff <= nh_in;  pend_ff <= pend_in;  rv_ff <= rv_in;
      end
      c_ff <= c_in;  fin_ff <= fin_in;  u_ff <= u_in;  fu_ff <= fu_in;  v_ff <= v_in;
      t_ff <= t_in;  walk_ff <= walk_in;  o_ff <= o_in;  dep_ff <= dep_in;
      p_ff <= p_in;  pat_ff <= pat_in;  pend_idx_ff <= pend_idx_in;
      pend_st_ff <= pend_st_in;  rs_ff <= rs_in;  rf_ff <= rf_in;  ri_ff <= ri_in;
      rp_ff <= rp_in;  rl_ff <= rl_in;
   end
endmodule

// ===== rtl/multi_pattern_matcher_unit.sv =====
// Aho-Corasick matcher over A..Z. Reset starts a clearing pass over the larger of
// MAX_NODES*ALPHABET_SIZE and MAX_PATTERNS entries (6656 by default) with busy high;
// a clear command repeats it and then answers. Build time grows with nodes, children
// and failure steps; a text letter's time grows with failure steps, hits and output
// links, all set by the registered memory reads.
// One item at a time; results strobe on rsp_valid for one cycle; the receiver cannot stall.
`include "assert_macros.svh"
module multi_pattern_matcher_unit
   import mpm_pkg::*;
#(
   parameter int MAX_NODES     = MAX_NODES_DEF,
   parameter int MAX_PATTERNS  = MAX_PATTERNS_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_letter,
   input  logic        req_last_letter,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [5:0]  rsp_pattern_index,
   output logic [31:0] rsp_start_position,
   output logic        rsp_last
);
   localparam int NW  = $clog2(MAX_NODES);
   localparam int CW  = $clog2(MAX_NODES * ALPHABET_SIZE);
   localparam int PW  = $clog2(MAX_PATTERNS + 1);
   localparam int PIW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

   mpm_we_type     we;
   logic [CW-1:0]  child_wa, child_ra;
   logic [NW-1:0]  child_wd, child_rd, node_wa, node_ra;
   logic [NW-1:0]  fail_wd, outl_wd, depth_wd, fail_rd, outl_rd, depth_rd;
   logic [PW-1:0]  first_wd, lastp_wd, first_rd, lastp_rd, pnext_wd, pnext_rd;
   logic [PIW-1:0] pnext_wa, pnext_ra;
   logic [NW-1:0]  bfs_wa, bfs_wd, bfs_ra, bfs_rd;

   mpm_ctrl #(
      .N(MAX_NODES), .P(MAX_PATTERNS), .A(ALPHABET_SIZE), .PB(POSITION_BITS),
      .NW(NW), .CW(CW), .PW(PW), .PIW(PIW)
   ) u_ctrl (
      .clock, .reset, .start, .busy, .req_command, .req_letter, .req_last_letter,
      .rsp_valid, .rsp_status, .rsp_found, .rsp_pattern_index, .rsp_start_position,
      .rsp_last, .we, .child_wa, .child_wd, .child_ra, .child_rd, .node_wa, .node_ra,
      .fail_wd, .outl_wd, .depth_wd, .first_wd, .lastp_wd, .fail_rd, .outl_rd,
      .depth_rd, .first_rd, .lastp_rd, .pnext_wa, .pnext_wd, .pnext_ra, .pnext_rd,
      .bfs_wa, .bfs_wd, .bfs_ra, .bfs_rd
   );

   mpm_store #(
      .N(MAX_NODES), .P(MAX_PATTERNS), .A(ALPHABET_SIZE),
      .NW(NW), .CW(CW), .PW(PW), .PIW(PIW)
   ) u_store (
      .clock, .we, .child_wa, .child_wd, .child_ra, .child_rd, .node_wa, .node_ra,
      .fail_wd, .outl_wd, .depth_wd, .first_wd, .lastp_wd, .fail_rd, .outl_rd,
      .depth_rd, .first_rd, .lastp_rd, .pnext_wa, .pnext_wd, .pnext_ra, .pnext_rd,
      .bfs_wa, .bfs_wd, .bfs_ra, .bfs_rd
   );

   `MPM_ASSERT_NR(a_reset_sweeps, clock, reset |=> busy)
   `MPM_ASSERT(a_beat_answered, clock, reset, (start && !busy) |=> (rsp_valid || busy))
   `MPM_ASSERT(a_hit_ok, clock, reset, (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
   `MPM_ASSERT(a_more_follows, clock, reset, (rsp_valid && !rsp_last) |-> busy)
   `MPM_ASSERT(a_miss_zero, clock, reset, (rsp_valid && !rsp_found) |-> (rsp_pattern_index == 6'd0))
endmodule
